### hdl/ptpq_pkg.sv
// Package for the process table priority queue: command and status codes,
// request, result and stored record structures. No dependencies.
package ptpq_pkg;

    typedef enum logic [2:0] {
        CMD_APPEND = 3'd0,
        CMD_LOOKUP = 3'd1,
        CMD_POP    = 3'd2,
        CMD_BEST   = 3'd3,
        CMD_DELETE = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  job_id;
        logic [7:0]  prio_in;
        logic [11:0] code_words_in;
        logic [11:0] input_words_in;
        logic [11:0] output_words_in;
        logic [11:0] temp_words_in;
        logic [15:0] disk_base_in;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  rec_id;
        logic [7:0]  rec_prio;
        logic [11:0] rec_code_words;
        logic [11:0] rec_input_words;
        logic [11:0] rec_output_words;
        logic [11:0] rec_temp_words;
        logic [15:0] rec_disk_base;
    } res_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [47:0] sizes;
        logic [15:0] disk_base;
    } entry_t;

endpackage

### hdl/process_table_priority_queue.sv
// Process table priority queue top level: record memory, search and compaction
// sequencer and result register. Depends on ptpq_pkg.
//
// Usage: requests enter on s_valid/s_ready with payload s_data (req_t); each
// request gives exactly one result on m_valid/m_ready with payload m_data.
// Records live in one synchronous memory of TABLE_DEPTH entries with one
// registered read port. For append, a spare code or an empty table, the
// sequencer goes from idle straight to its done state, and the result then
// passes the pending result register into the output register.
// Lookup and best scan the whole table one entry a cycle. Pop and delete scan
// too, then close the gap by moving each later record down one place with one
// read and one write a cycle.
// One request is in work at a time. s_ready is high when the sequencer is idle
// and no finished result is waiting to enter the output register, so the next
// request can be taken in the same cycle as a result appears on m_valid.
// Reset empties the table at once (the count is cleared; no memory sweep).
// When the receiver stalls, the result holds in m_data and the next request
// is taken but its result waits until the register is free.
module process_table_priority_queue
    import ptpq_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam res_t RES_FULL  = '{status: ST_FULL, default: '0};
    localparam res_t RES_EMPTY = '{status: ST_EMPTY, default: '0};

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SHIFT, S_DONE
    } state_t;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    state_t        state_reg;
    logic [CW-1:0] count_reg;
    req_t          req_reg;
    logic [CW-1:0] idx_reg;
    logic          rd_vld_reg;
    logic [CW-1:0] rd_idx_reg;
    logic          hit_reg;
    logic [CW-1:0] hit_idx_reg;
    entry_t        hit_rec_reg;
    res_t          res_reg;
    logic          res_pend_reg;
    logic          m_valid_reg;
    res_t          m_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    assign s_ready = (state_reg == S_IDLE) && !res_pend_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    logic cand;
    always_comb begin
        cand = 1'b0;
        case (req_reg.cmd) inside
            CMD_LOOKUP, CMD_DELETE: cand = !hit_reg && (rd_data.id == req_reg.job_id);
            CMD_BEST: cand = !hit_reg || (rd_data.prio < hit_rec_reg.prio);
            CMD_POP: cand = !hit_reg;
            default: cand = 1'b0;
        endcase
    end

    always_comb begin
        rd_addr = idx_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = '{id: s_data.job_id, prio: s_data.prio_in,
                    sizes: {s_data.temp_words_in, s_data.output_words_in,
                            s_data.input_words_in, s_data.code_words_in},
                    disk_base: s_data.disk_base_in};
        if (state_reg == S_IDLE) begin
            wr_en = s_valid && s_ready && (s_data.cmd == CMD_APPEND) &&
                    (count_reg < CW'(TABLE_DEPTH));
        end else if (state_reg == S_SHIFT && rd_vld_reg) begin
            wr_en   = 1'b1;
            wr_addr = AW'(rd_idx_reg - 1'b1);
            wr_data = rd_data;
        end
    end

    function automatic res_t rec_res(entry_t e);
        res_t r;
        r.status           = ST_OK;
        r.rec_id           = e.id;
        r.rec_prio         = e.prio;
        r.rec_code_words   = e.sizes[11:0];
        r.rec_input_words  = e.sizes[23:12];
        r.rec_output_words = e.sizes[35:24];
        r.rec_temp_words   = e.sizes[47:36];
        r.rec_disk_base    = e.disk_base;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            res_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            hit_reg      <= 1'b0;
        end else begin
            if (res_pend_reg && (!m_valid_reg || m_ready)) begin
                m_valid_reg  <= 1'b1;
                m_data_reg   <= res_reg;
                res_pend_reg <= 1'b0;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        req_reg    <= s_data;
                        idx_reg    <= '0;
                        rd_vld_reg <= 1'b0;
                        hit_reg    <= 1'b0;
                        if (s_data.cmd == CMD_APPEND) begin
                            if (count_reg < CW'(TABLE_DEPTH)) begin
                                count_reg <= count_reg + 1'b1;
                                res_reg   <= '0;
                            end else begin
                                res_reg <= RES_FULL;
                            end
                            state_reg <= S_DONE;
                        end else if (s_data.cmd == CMD_LOOKUP || s_data.cmd == CMD_POP ||
                                     s_data.cmd == CMD_BEST || s_data.cmd == CMD_DELETE) begin
                            if (count_reg == '0) begin
                                res_reg   <= RES_EMPTY;
                                state_reg <= S_DONE;
                            end else begin
                                res_reg   <= '0;
                                state_reg <= S_SCAN;
                            end
                        end else begin
                            res_reg   <= '0;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    rd_idx_reg <= idx_reg;
                    if (rd_vld_reg && cand) begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= rd_idx_reg;
                        hit_rec_reg <= rd_data;
                    end
                    if (rd_vld_reg && !(idx_reg < count_reg)) begin
                        rd_vld_reg <= 1'b0;
                        if (!hit_reg && !cand) begin
                            res_reg.status <= ST_NOTFOUND;
                            state_reg      <= S_DONE;
                        end else begin
                            res_reg <= rec_res((hit_reg && !(cand && req_reg.cmd == CMD_BEST))
                                               ? hit_rec_reg : rd_data);
                            if (req_reg.cmd == CMD_POP || req_reg.cmd == CMD_DELETE) begin
                                idx_reg   <= (hit_reg ? hit_idx_reg : rd_idx_reg) + 1'b1;
                                state_reg <= S_SHIFT;
                            end else begin
                                state_reg <= S_DONE;
                            end
                        end
                    end else begin
                        rd_vld_reg <= (idx_reg < count_reg);
                        idx_reg    <= idx_reg + 1'b1;
                    end
                end
                S_SHIFT: begin
                    rd_vld_reg <= (idx_reg < count_reg);
                    rd_idx_reg <= idx_reg;
                    idx_reg    <= idx_reg + 1'b1;
                    if (!(idx_reg < count_reg) && !rd_vld_reg) begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    res_pend_reg <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != S_IDLE))
        else $error("accepted request did not start work");
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");
`endif

endmodule

### verif/tb.sv
// Testbench for the process table priority queue: a queued request driver, a
// result monitor and a scoreboard fed by a table model of its own.
// Depends on ptpq_pkg and process_table_priority_queue.
module tb
    import ptpq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 32;
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_data;
    logic m_valid;
    logic m_ready;
    res_t m_data;

    process_table_priority_queue #(.TABLE_DEPTH(DEPTH)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    entry_t table_rows[DEPTH];
    int     row_count;
    req_t   pending_reqs[$];
    res_t   expected_results[$];
    int     errors;
    int     results_seen;
    int     appends_ok;
    int     fulls_seen;
    int     not_found_seen;
    bit     stim_done;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic res_t record_of(int k);
        res_t r;
        r = '0;
        r.rec_id           = table_rows[k].id;
        r.rec_prio         = table_rows[k].prio;
        r.rec_code_words   = table_rows[k].sizes[11:0];
        r.rec_input_words  = table_rows[k].sizes[23:12];
        r.rec_output_words = table_rows[k].sizes[35:24];
        r.rec_temp_words   = table_rows[k].sizes[47:36];
        r.rec_disk_base    = table_rows[k].disk_base;
        return r;
    endfunction

    function automatic void close_gap(int k);
        for (int i = k; i + 1 < row_count; i++) table_rows[i] = table_rows[i + 1];
        row_count--;
    endfunction

    function automatic res_t table_answer(req_t q);
        res_t r;
        int   pos;
        r = '0;
        r.status = ST_OK;
        pos = -1;
        case (q.cmd)
            CMD_APPEND: begin
                if (row_count >= DEPTH) begin
                    r.status = ST_FULL;
                    fulls_seen++;
                end else begin
                    table_rows[row_count].id        = q.job_id;
                    table_rows[row_count].prio      = q.prio_in;
                    table_rows[row_count].sizes     = {q.temp_words_in, q.output_words_in,
                                                       q.input_words_in, q.code_words_in};
                    table_rows[row_count].disk_base = q.disk_base_in;
                    row_count++;
                    appends_ok++;
                end
            end
            CMD_LOOKUP, CMD_DELETE: begin
                if (row_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < row_count; i++)
                        if (pos < 0 && table_rows[i].id == q.job_id) pos = i;
                    if (pos < 0) begin
                        r.status = ST_NOTFOUND;
                        not_found_seen++;
                    end else begin
                        r = record_of(pos);
                        if (q.cmd == CMD_DELETE) close_gap(pos);
                    end
                end
            end
            CMD_POP: begin
                if (row_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r = record_of(0);
                    close_gap(0);
                end
            end
            CMD_BEST: begin
                if (row_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos = 0;
                    for (int i = 1; i < row_count; i++)
                        if (table_rows[pos].prio > table_rows[i].prio) pos = i;
                    r = record_of(pos);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic req_t make_req(logic [2:0] c, logic [7:0] id);
        req_t q;
        q.cmd             = c;
        q.job_id          = id;
        q.prio_in         = 8'($urandom());
        q.code_words_in   = 12'($urandom());
        q.input_words_in  = 12'($urandom());
        q.output_words_in = 12'($urandom());
        q.temp_words_in   = 12'($urandom());
        q.disk_base_in    = 16'($urandom());
        return q;
    endfunction

    // Driver: one request at a time, with a random gap before each.
    int gap_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_data   <= '0;
            gap_left <= $urandom_range(0, 11);
        end else if (s_valid && !s_ready) begin
        end else if (s_valid && s_ready && (pending_reqs.size() == 0 || gap_left != 0)) begin
            s_valid <= 1'b0;
            if (s_valid) expected_results.push_back(table_answer(s_data));
        end else if (s_valid && s_ready) begin
            expected_results.push_back(table_answer(s_data));
            s_data   <= pending_reqs.pop_front();
            gap_left <= $urandom_range(0, 11);
        end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
        end else if (pending_reqs.size() != 0) begin
            s_valid  <= 1'b1;
            s_data   <= pending_reqs.pop_front();
            gap_left <= $urandom_range(0, 11);
        end
    end

    // Monitor: random back-pressure, every result checked against the oldest
    // expectation.
    int stall_left;
    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_data);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data !== want) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, m_data);
                        errors++;
                    end
                end
                m_ready    <= 1'b0;
                stall_left <= $urandom_range(0, 11);
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [2:0] c;
        int         mode;
        aresetn    = 1'b0;
        errors     = 0;
        row_count  = 0;
        results_seen = 0;
        appends_ok = 0;
        fulls_seen = 0;
        not_found_seen = 0;
        stim_done  = 1'b0;
        // Directed: empty table, extremes, spare codes, ties.
        pending_reqs.push_back(make_req(CMD_POP, 8'd0));
        pending_reqs.push_back(make_req(CMD_BEST, 8'd0));
        pending_reqs.push_back(make_req(CMD_LOOKUP, 8'd1));
        pending_reqs.push_back(make_req(CMD_DELETE, 8'hff));
        pending_reqs.push_back(make_req(CMD_SPARE_LO, 8'hff));
        pending_reqs.push_back(make_req(CMD_SPARE_HI, 8'h00));
        pending_reqs.push_back('{CMD_APPEND, 8'hff, 8'hff, 12'hfff, 12'hfff, 12'hfff,
                                 12'hfff, 16'hffff});
        pending_reqs.push_back('{CMD_APPEND, 8'h00, 8'h00, 12'h0, 12'h0, 12'h0, 12'h0,
                                 16'h0});
        pending_reqs.push_back('{CMD_APPEND, 8'h00, 8'h00, 12'h5a5, 12'ha5a, 12'h123,
                                 12'hedc, 16'h8001});
        pending_reqs.push_back(make_req(CMD_BEST, 8'd0));
        pending_reqs.push_back(make_req(CMD_LOOKUP, 8'h00));
        pending_reqs.push_back(make_req(CMD_LOOKUP, 8'h42));
        pending_reqs.push_back(make_req(CMD_DELETE, 8'h00));
        pending_reqs.push_back(make_req(CMD_POP, 8'd0));
        pending_reqs.push_back(make_req(CMD_POP, 8'd0));
        pending_reqs.push_back(make_req(CMD_POP, 8'd0));
        // Random: bursts of appends to fill and drain, ids from a narrow pool.
        for (int n = 0; n < 1700; n++) begin
            mode = $urandom_range(0, 99);
            if (mode < 40) c = CMD_APPEND;
            else if (mode < 55) c = CMD_LOOKUP;
            else if (mode < 70) c = CMD_POP;
            else if (mode < 82) c = CMD_BEST;
            else if (mode < 97) c = CMD_DELETE;
            else c = 3'($urandom_range(5, 7));
            if ((n / 200) % 2 == 1 && mode < 70) c = CMD_APPEND;
            pending_reqs.push_back(make_req(c, ($urandom_range(0, 3) == 0) ? 8'($urandom())
                                                : 8'($urandom_range(0, 15))));
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_reqs.size() != 0 || s_valid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        $display("Ran %0d results: %0d appends, %0d full refusals, %0d id misses.",
                 results_seen, appends_ok, fulls_seen, not_found_seen);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule
